// ===== rtl/core/bsfb_pkg.sv =====
// Shared types, constants and the escape function of the byte stuffing framer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bsfb_pkg;

    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_FLAG   = 8'h5E;
    localparam logic [7:0] ESC_ESC    = 8'h5D;
    localparam logic [7:0] ADDR_RESET = 8'h03;

    // Longest expansion of one input: 4 header, 2 data, 2 check, 1 flag.
    localparam int BURST_MAX = 9;
    localparam int POS_W     = $clog2(BURST_MAX);
    localparam int CNT_W     = $clog2(BURST_MAX + 1);

    // Configuration register map (word index taken from paddr[2]).
    localparam int          PADDR_W   = 3;
    localparam logic        REG_ADDR  = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       seq_bit;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
    } t_out_item;

    // Expanded line bytes of one input, packed from index 0 upwards.
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
    } t_burst;

    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_esc;

    function automatic t_esc escape_byte(input logic [7:0] b);
        t_esc e;
        e.two = 1'b0;
        e.b0  = b;
        e.b1  = 8'h00;
        if (b == FLAG_BYTE) begin
            e.two = 1'b1;
            e.b0  = ESC_BYTE;
            e.b1  = ESC_FLAG;
        end else if (b == ESC_BYTE) begin
            e.two = 1'b1;
            e.b0  = ESC_BYTE;
            e.b1  = ESC_ESC;
        end
        return e;
    endfunction

endpackage

// ===== rtl/core/byte_stuffing_frame_builder.sv =====
// Top level of the HDLC-like byte stuffing framer with XOR block check.
// Depends on bsfb_pkg, bsfb_apb_regs, bsfb_builder and bsfb_emitter.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_valid / o_stall / i_data): one raw payload byte per
//   transaction, marked as opening and/or closing a frame.
//   Output channel (o_valid / i_stall / o_data): one line byte per
//   transaction; run_end marks the last line byte caused by an input.
//   APB port: address register at byte address 0; write it only while idle.
// Path: an accepted byte passes the input register, then the burst register,
//   before its first line byte shows.
// Throughput: one line byte per cycle while i_stall is low, set by the single
//   output byte lane. An input occupies the serialiser while its line bytes
//   are taken: 1 or 2 for a plain byte, up to 9 for a one-byte frame. The next
//   input is moved into the burst register in the cycle its predecessor's last
//   byte is taken, so back-to-back inputs leave no gap on the line.
// Stall: while the receiver stalls, hold the current line byte; one more
//   input is still taken into the input register before o_stall rises.
// Reset: synchronous, active low; clears the pipeline, the running check,
//   and sets the address to 0x03.
module byte_stuffing_frame_builder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  bsfb_pkg::t_in_item           i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output bsfb_pkg::t_out_item          o_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsfb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import bsfb_pkg::*;

    logic [7:0] address;
    logic       can_load;
    logic       load;
    t_burst     burst;

    // Configuration register
    bsfb_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_address (address)
    );

    // Hold the input, expand it into header, stuffed bytes and trailer
    bsfb_builder u_builder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .i_address  (address),
        .i_can_load (can_load),
        .o_load     (load),
        .o_burst    (burst)
    );

    // Advance through the burst one line byte per taken transaction
    bsfb_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_burst    (burst),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

endmodule

// ===== rtl/core/bsfb_apb_regs.sv =====
// APB-style configuration port holding the frame address register.
// Depends on bsfb_pkg.
`timescale 1ns / 1ps

module bsfb_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsfb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [7:0]                   o_address
);
    import bsfb_pkg::*;

    logic [7:0] r_address;
    logic       hit;

    assign hit    = (paddr[2] == REG_ADDR);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address <= ADDR_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_address <= pwdata[7:0];
        end
    end

    assign prdata    = hit ? {24'h000000, r_address} : 32'h0000_0000;
    assign o_address = r_address;

endmodule

// ===== rtl/core/bsfb_builder.sv =====
// Input register, frame expansion logic and running payload check.
// Depends on bsfb_pkg; feeds bsfb_emitter with one expanded burst per item.
`timescale 1ns / 1ps

module bsfb_builder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  bsfb_pkg::t_in_item i_data,
    input  logic [7:0]         i_address,
    input  logic               i_can_load,
    output logic               o_load,
    output bsfb_pkg::t_burst   o_burst
);
    import bsfb_pkg::*;

    t_in_item         r_in;
    logic             r_in_valid;
    logic [7:0]       r_xor;
    logic [7:0]       n_xor;
    logic [7:0]       chk;
    logic [7:0]       ctrl;
    t_esc             esc_d;
    t_esc             esc_c;
    logic [POS_W-1:0] pos;
    t_burst           burst;

    assign o_load  = r_in_valid && i_can_load;
    assign o_stall = r_in_valid && !i_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (o_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    // Restart the check on an opening byte, clear it once it has gone out.
    assign chk   = (r_in.first_byte ? 8'h00 : r_xor) ^ r_in.data_byte;
    assign n_xor = r_in.last_byte ? 8'h00 : chk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor <= 8'h00;
        end else if (o_load) begin
            r_xor <= n_xor;
        end
    end

    assign ctrl  = {1'b0, r_in.seq_bit, 6'b000000};
    assign esc_d = escape_byte(r_in.data_byte);
    assign esc_c = escape_byte(chk);

    // Pack the header on an opening byte, the data, and on a closing byte the check and flag, back to back.
    always_comb begin
        burst.bytes = '0;
        pos         = '0;
        if (r_in.first_byte) begin
            burst.bytes[0] = FLAG_BYTE;
            burst.bytes[1] = i_address;
            burst.bytes[2] = ctrl;
            burst.bytes[3] = i_address ^ ctrl;
            pos            = POS_W'(4);
        end
        burst.bytes[pos] = esc_d.b0;
        if (esc_d.two) begin
            burst.bytes[pos + POS_W'(1)] = esc_d.b1;
            pos = pos + POS_W'(2);
        end else begin
            pos = pos + POS_W'(1);
        end
        if (r_in.last_byte) begin
            burst.bytes[pos] = esc_c.b0;
            if (esc_c.two) begin
                burst.bytes[pos + POS_W'(1)] = esc_c.b1;
                pos = pos + POS_W'(2);
            end else begin
                pos = pos + POS_W'(1);
            end
            burst.bytes[pos] = FLAG_BYTE;
            pos = pos + POS_W'(1);
        end
        burst.cnt = CNT_W'(pos);
    end

    assign o_burst = burst;

    a_xor_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && r_in.last_byte) |=> (r_xor == 8'h00))
        else $error("payload check not cleared after closing byte");

    a_load_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> r_in_valid && (burst.cnt != '0))
        else $error("burst loaded without a held item");

endmodule

// ===== rtl/core/bsfb_emitter.sv =====
// Burst register and byte serialiser driving the line-side channel.
// Depends on bsfb_pkg; takes bursts from bsfb_builder.
`timescale 1ns / 1ps

module bsfb_emitter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bsfb_pkg::t_burst    i_burst,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_stall,
    output bsfb_pkg::t_out_item o_data
);
    import bsfb_pkg::*;

    logic [BURST_MAX-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]          r_cnt;
    logic [POS_W-1:0]          r_idx;
    logic                      r_busy;
    logic                      at_last;

    assign at_last    = (CNT_W'(r_idx) == r_cnt - CNT_W'(1));
    assign o_can_load = !r_busy || (at_last && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && !i_stall) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_cnt   <= i_burst.cnt;
        end
    end

    assign o_valid         = r_busy;
    assign o_data.out_byte = r_bytes[r_idx];
    assign o_data.run_end  = at_last;

    a_idx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (CNT_W'(r_idx) < r_cnt))
        else $error("byte index beyond burst length");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_busy || (at_last && !i_stall)))
        else $error("burst overwritten before its last byte was taken");

endmodule
